>>> design/modbus_rtu_response_receiver_top_macros.svh
// ----------------------------------------------------------------------------
// Modbus RTU response receiver assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_RESPONSE_RECEIVER_TOP_MACROS_SVH
`define MODBUS_RTU_RESPONSE_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication
`define MBRX_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define MBRX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/mbrx_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU response receiver package
// Frame phases, result kinds, register indexes and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package mbrx_pkg;

   // Frame phase codes; unused codes act as idle
   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_FUNCTION = 3'd1,
      PH_COUNT    = 3'd2,
      PH_DATA     = 3'd3,
      PH_CRC_LO   = 3'd4,
      PH_CRC_HI   = 3'd5
   } phase_type;

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_CRC_GOOD = 2'd1;
   localparam logic [1:0] KIND_CRC_BAD  = 2'd2;
   localparam logic [1:0] KIND_UNUSED   = 2'd3;

   // Register indexes
   localparam logic CSR_SLAVE_ID = 1'b0;
   localparam logic CSR_FUNCTION = 1'b1;

   // Register reset values
   localparam logic [7:0] SLAVE_ID_RESET = 8'd1;
   localparam logic [6:0] FUNCTION_RESET = 7'd3;

   // Reflected CRC-16 constants
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // Advance the running CRC by one byte, LSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> design/modbus_rtu_response_receiver_top.sv
// ----------------------------------------------------------------------------
// Modbus RTU response receiver
// Parses read-response frames byte by byte, emits each payload byte with its
// index and a good/bad CRC result after the CRC high byte.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Payload
//   req_     in         req_valid / req_stall   rx_byte
//   rsp_     out        rsp_valid / rsp_stall   kind, data, byte_index
//   csr_     in         csr_write_enable        csr_index, csr_write_data
//
// One byte per cycle sustained while results are not stalled; a byte is
// registered in the input register on transfer, its result in the result
// register. The CRC register is advanced by an unrolled 8-step shift of the
// input byte. Reset clears the frame state to idle with CRC 0xFFFF
// and restores the register defaults. A stalled result holds, and the input
// register stalls only when it holds a byte that cannot advance.
// ----------------------------------------------------------------------------
`include "modbus_rtu_response_receiver_top_macros.svh"

module modbus_rtu_response_receiver_top
   import mbrx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data,
   output logic [7:0] rsp_byte_index,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data
);

   // Configuration registers
   logic [7:0]  slave_id_ff;
   logic [6:0]  function_ff;

   // Input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;

   // Frame state
   phase_type   phase_ff, phase_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;

   // Result register
   logic        out_valid_ff;
   logic [1:0]  out_kind_ff;
   logic [7:0]  out_data_ff;
   logic [7:0]  out_index_ff;

   // Parse results
   logic        res_valid;
   logic [1:0]  res_kind;
   logic [7:0]  res_data;
   logic [7:0]  res_index;
   logic [7:0]  pos_next;

   logic        advance;
   logic        process;
   logic        accept;

   // Move a byte on when the result register is free or being drained
   assign advance   = !out_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_kind_ff;
   assign rsp_data       = out_data_ff;
   assign rsp_byte_index = out_index_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_id_ff <= SLAVE_ID_RESET;
         function_ff <= FUNCTION_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SLAVE_ID: slave_id_ff <= csr_write_data;
            CSR_FUNCTION: function_ff <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   // Capture the incoming byte
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (process) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Hold frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         len_ff    <= 8'd0;
         pos_ff    <= 8'd0;
         crc_ff    <= CRC_INIT;
         crc_lo_ff <= 8'd0;
      end else begin
         phase_ff  <= phase_in;
         len_ff    <= len_in;
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         crc_lo_ff <= crc_lo_in;
      end
   end

   assign pos_next = pos_ff + 8'd1;

   // Parse one byte: next state and result
   always_comb begin
      phase_in  = phase_ff;
      len_in    = len_ff;
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      crc_lo_in = crc_lo_ff;
      res_valid = 1'b0;
      res_kind  = KIND_PAYLOAD;
      res_data  = in_byte_ff;
      res_index = pos_ff;
      if (process) begin
         case (phase_ff)
            PH_FUNCTION: begin
               if (in_byte_ff == {1'b0, function_ff}) begin
                  crc_in   = crc_byte(crc_ff, in_byte_ff);
                  phase_in = PH_COUNT;
               end else begin
                  crc_in   = CRC_INIT;
                  phase_in = PH_IDLE;
               end
            end
            PH_COUNT: begin
               crc_in   = crc_byte(crc_ff, in_byte_ff);
               len_in   = in_byte_ff;
               pos_in   = 8'd0;
               phase_in = (in_byte_ff == 8'd0) ? PH_CRC_LO : PH_DATA;
            end
            PH_DATA: begin
               crc_in    = crc_byte(crc_ff, in_byte_ff);
               res_valid = 1'b1;
               pos_in    = pos_next;
               if (pos_next >= len_ff) begin
                  phase_in = PH_CRC_LO;
               end
            end
            PH_CRC_LO: begin
               crc_lo_in = in_byte_ff;
               phase_in  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
               res_valid = 1'b1;
               res_kind  = ({in_byte_ff, crc_lo_ff} == crc_ff) ? KIND_CRC_GOOD : KIND_CRC_BAD;
               res_data  = len_ff;
               res_index = 8'd0;
               crc_in    = CRC_INIT;
               phase_in  = PH_IDLE;
            end
            default: begin
               // Idle: look for the slave id, restart the CRC
               if (in_byte_ff == slave_id_ff) begin
                  crc_in   = crc_byte(CRC_INIT, in_byte_ff);
                  phase_in = PH_FUNCTION;
               end else begin
                  crc_in   = CRC_INIT;
                  phase_in = PH_IDLE;
               end
            end
         endcase
      end
   end

   // Load or drain the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= process && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (process && res_valid) begin
         out_kind_ff  <= res_kind;
         out_data_ff  <= res_data;
         out_index_ff <= res_index;
      end
   end

   // Checks
   `MBRX_ASSERT_SAME(a_end_index_zero, clock, reset,
      rsp_valid && (rsp_kind != KIND_PAYLOAD), rsp_byte_index == 8'd0,
      "frame-end result with nonzero index")
   `MBRX_ASSERT_SAME(a_kind_legal, clock, reset,
      rsp_valid, rsp_kind != KIND_UNUSED,
      "unused result kind")
   `MBRX_ASSERT_SAME(a_index_in_range, clock, reset,
      rsp_valid && (rsp_kind == KIND_PAYLOAD), rsp_byte_index < len_ff,
      "payload index beyond byte count")
   `MBRX_ASSERT_NEXT(a_idle_no_result, clock, reset,
      process && (phase_ff == PH_IDLE), !out_valid_ff,
      "result produced from idle byte")
   `MBRX_ASSERT_NEXT(a_end_restarts, clock, reset,
      process && (phase_ff == PH_CRC_HI), (phase_ff == PH_IDLE) && (crc_ff == CRC_INIT),
      "frame end did not restart parser")

endmodule

>>> dv/tb_modbus_rtu_response_receiver_top.sv
// ----------------------------------------------------------------------------
// Modbus RTU response receiver testbench
// Feeds read-response frames byte by byte, with random bursts and gaps on the
// byte side and random stalls on the result side. A local frame parser and
// CRC-16 tracker predict each payload and frame-end result, and every result
// transfer is checked in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_response_receiver_top
   import mbrx_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASE_BYTES  = 250;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [7:0] byte_index;
   } rx_result_type;

   // DUT connections
   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte      = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_data;
   logic [7:0] rsp_byte_index;
   logic       csr_write_enable = 1'b0;
   logic       csr_index        = 1'b0;
   logic [7:0] csr_write_data   = 8'h00;

   // Parser state and register copies
   phase_type   p_phase;
   logic [7:0]  p_len;
   logic [7:0]  p_pos;
   logic [15:0] p_crc;
   logic [7:0]  p_crc_lo;
   logic [7:0]  cfg_slave_id;
   logic [6:0]  cfg_function;

   rx_result_type rx_results_due[$];
   int         bad_results = 0;
   int         cycle_count = 0;
   int         bytes_sent  = 0;
   int         burst_left  = 1;
   int         stall_run   = 0;
   int         stall_mode  = 0;

   modbus_rtu_response_receiver_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data         (rsp_data),
      .rsp_byte_index   (rsp_byte_index),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Bit-serial reflected CRC-16 update, LSB of the byte first
   function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] octet);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ octet[i];
         r  = {1'b0, r[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

   function automatic void parser_reset();
      cfg_slave_id = SLAVE_ID_RESET;
      cfg_function = FUNCTION_RESET;
      p_phase      = PH_IDLE;
      p_len        = 8'd0;
      p_pos        = 8'd0;
      p_crc        = CRC_INIT;
      p_crc_lo     = 8'd0;
   endfunction

   // Advance the frame parser by one transferred byte, queue any result
   function automatic void parse_byte(input logic [7:0] b);
      rx_result_type r;
      logic [15:0]   got;
      case (p_phase)
         PH_FUNCTION: begin
            if (b == {1'b0, cfg_function}) begin
               p_crc   = crc16_step(p_crc, b);
               p_phase = PH_COUNT;
            end else begin
               p_phase = PH_IDLE;
               p_crc   = CRC_INIT;
            end
         end
         PH_COUNT: begin
            p_crc   = crc16_step(p_crc, b);
            p_len   = b;
            p_pos   = 8'd0;
            p_phase = (b == 8'd0) ? PH_CRC_LO : PH_DATA;
         end
         PH_DATA: begin
            p_crc        = crc16_step(p_crc, b);
            r.kind       = KIND_PAYLOAD;
            r.data       = b;
            r.byte_index = p_pos;
            rx_results_due.push_back(r);
            p_pos = p_pos + 8'd1;
            if (p_pos >= p_len) begin
               p_phase = PH_CRC_LO;
            end
         end
         PH_CRC_LO: begin
            p_crc_lo = b;
            p_phase  = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            got          = {b, p_crc_lo};
            r.kind       = (got == p_crc) ? KIND_CRC_GOOD : KIND_CRC_BAD;
            r.data       = p_len;
            r.byte_index = 8'd0;
            rx_results_due.push_back(r);
            p_phase = PH_IDLE;
            p_crc   = CRC_INIT;
         end
         default: begin
            // Idle, and any unused phase code
            p_crc = CRC_INIT;
            if (b == cfg_slave_id) begin
               p_crc   = crc16_step(CRC_INIT, b);
               p_phase = PH_FUNCTION;
            end else begin
               p_phase = PH_IDLE;
            end
         end
      endcase
   endfunction

   function automatic void note_mismatch(input string what, input rx_result_type want,
                                         input rx_result_type seen);
      bad_results++;
      if (bad_results <= 10) begin
         $display("%0t %s: expected kind %0d data %02h index %0d, got kind %0d data %02h index %0d",
                  $time, what, want.kind, want.data, want.byte_index,
                  seen.kind, seen.data, seen.byte_index);
      end
   endfunction

   // Send one byte: hold it until transfer, then maybe open a gap
   task automatic send_byte(input logic [7:0] b);
      int gap;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      parse_byte(b);
      bytes_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Send a frame with its CRC; cut >= 0 stops after that many bytes
   task automatic send_frame(input logic [7:0] id, input logic [7:0] func,
                             input logic [7:0] count, input int fill,
                             input logic [15:0] crc_flip, input int cut);
      logic [15:0] crc;
      logic [15:0] field;
      logic [7:0]  b;
      int          total;
      total = count + 5;
      if (cut >= 0 && cut < total) begin
         total = cut;
      end
      crc   = CRC_INIT;
      field = 16'h0000;
      for (int k = 0; k < total; k++) begin
         if (k == 0) begin
            b = id;
         end else if (k == 1) begin
            b = func;
         end else if (k == 2) begin
            b = count;
         end else if (k < count + 3) begin
            b = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
         end else if (k == count + 3) begin
            field = crc ^ crc_flip;
            b     = field[7:0];
         end else begin
            b = field[15:8];
         end
         if (k < count + 3) begin
            crc = crc16_step(crc, b);
         end
         send_byte(b);
      end
   endtask

   // Drop valid, wait for every predicted result, then let the pipeline empty
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (rx_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      if (idx == CSR_SLAVE_ID) begin
         cfg_slave_id = val;
      end else begin
         cfg_function = val[6:0];
      end
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Reset register values, two-byte payload of all ones
   task automatic test_default_frame();
      send_frame(SLAVE_ID_RESET, {1'b0, FUNCTION_RESET}, 8'd2, 255, 16'h0000, -1);
   endtask

   // Count byte of zero goes straight to the CRC bytes
   task automatic test_zero_count();
      send_frame(SLAVE_ID_RESET, {1'b0, FUNCTION_RESET}, 8'd0, -1, 16'h0000, -1);
   endtask

   // Corrupt the top CRC bit on a one-byte zero payload
   task automatic test_crc_error();
      send_frame(SLAVE_ID_RESET, {1'b0, FUNCTION_RESET}, 8'd1, 0, 16'h8000, -1);
   endtask

   // Exception function code and a foreign slave id are both dropped
   task automatic test_dropped_frames();
      send_frame(SLAVE_ID_RESET, {1'b1, FUNCTION_RESET}, 8'd0, -1, 16'h0000, 2);
      send_byte(8'h02);
   endtask

   // A cut frame swallows the bytes of the next one
   task automatic test_truncated_frame();
      send_frame(SLAVE_ID_RESET, {1'b0, FUNCTION_RESET}, 8'd2, -1, 16'h0000, 4);
      send_frame(SLAVE_ID_RESET, {1'b0, FUNCTION_RESET}, 8'd0, -1, 16'h0000, -1);
   endtask

   // Change the function register between the id byte and the function byte
   task automatic test_config_mid_frame();
      logic [15:0] crc;
      wait_idle();
      send_byte(SLAVE_ID_RESET);
      wait_idle();
      write_reg(CSR_FUNCTION, 8'hFF);
      crc = crc16_step(CRC_INIT, SLAVE_ID_RESET);
      crc = crc16_step(crc, 8'h7F);
      crc = crc16_step(crc, 8'h00);
      send_byte(8'h7F);
      send_byte(8'h00);
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
      wait_idle();
   endtask

   // Mostly well-formed frames with random content, some noise and damage
   task automatic send_random_frame();
      logic [7:0]  id;
      logic [7:0]  func;
      logic [7:0]  count;
      logic [15:0] flip;
      int          pick;
      int          cut;
      int          n;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         n = $urandom_range(1, 3);
         repeat (n) send_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 99) < 88) begin
         id = cfg_slave_id;
      end else begin
         id = 8'($urandom_range(0, 255));
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         func = {1'b0, cfg_function};
      end else if (pick < 88) begin
         func = {1'b1, cfg_function};
      end else begin
         func = 8'($urandom_range(0, 255));
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         count = 8'($urandom_range(100, 255));
      end else if (pick < 14) begin
         count = 8'd0;
      end else begin
         count = 8'($urandom_range(1, 8));
      end
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
         flip = 16'h0000;
      end else if (pick < 93) begin
         flip = 16'h0001 << $urandom_range(0, 15);
      end else begin
         flip = 16'($urandom_range(1, 65535));
      end
      cut = ($urandom_range(0, 99) < 6) ? int'($urandom_range(1, count + 4)) : -1;
      send_frame(id, func, count, -1, flip, cut);
   endtask

   // Random traffic over several register settings, extremes included
   task automatic test_random_traffic();
      logic [7:0] id_val;
      logic [7:0] fn_val;
      int         start;
      for (int s = 0; s < 6; s++) begin
         case (s)
            0: begin id_val = 8'd1;   fn_val = 8'd3;   end
            1: begin id_val = 8'd0;   fn_val = 8'd0;   end
            2: begin id_val = 8'd247; fn_val = 8'd127; end
            3: begin id_val = 8'd255; fn_val = 8'hFF;  end
            4: begin id_val = 8'h80;  fn_val = 8'h80;  end
            default: begin
               id_val = 8'($urandom_range(0, 255));
               fn_val = 8'($urandom_range(0, 255));
            end
         endcase
         wait_idle();
         write_reg(CSR_SLAVE_ID, id_val);
         write_reg(CSR_FUNCTION, fn_val);
         start = bytes_sent;
         while (bytes_sent - start < PHASE_BYTES) send_random_frame();
         wait_idle();
      end
   endtask

   // Result side stall pattern: free runs, light, even and heavy stalling
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_run  <= $urandom_range(5, 60);
      end else begin
         stall_run <= stall_run - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= 1'($urandom_range(0, 1));
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Compare every result transfer with the oldest prediction
   always @(posedge clock) begin : check_rsp
      rx_result_type want;
      rx_result_type seen;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         seen = {rsp_kind, rsp_data, rsp_byte_index};
         if (rx_results_due.size() == 0) begin
            want = '0;
            note_mismatch("unexpected result", want, seen);
         end else begin
            want = rx_results_due.pop_front();
            if (want !== seen) begin
               note_mismatch("result mismatch", want, seen);
            end
         end
      end
   end

   // Guard against a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      parser_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_frame();
      test_zero_count();
      test_crc_error();
      test_dropped_frames();
      test_truncated_frame();
      test_config_mid_frame();
      test_random_traffic();

      // Drain with a bound, then flag anything still outstanding
      req_valid <= 1'b0;
      for (int n = 0; n < 2000 && rx_results_due.size() != 0; n++) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (rx_results_due.size() != 0) begin
         if (bad_results < 10) begin
            $display("%0d results never arrived", rx_results_due.size());
         end
         bad_results += rx_results_due.size();
      end

      if (bad_results == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
